// ===== src/point_triangle_distance_2d_core_assert.svh =====
// ----------------------------------------------------------------------------
// point_triangle_distance_2d_core_assert.svh
// assertion macros shared by the distance core, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef POINT_TRIANGLE_DISTANCE_2D_CORE_ASSERT_SVH
`define POINT_TRIANGLE_DISTANCE_2D_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PTD2D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTD2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptd2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd2d_pkg
// register indexes, region codes and result widths of the 2d point to
// triangle distance core
// ----------------------------------------------------------------------------
package ptd2d_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_V0X = 3'd0;
    localparam t_cfg_idx REG_V0Y = 3'd1;
    localparam t_cfg_idx REG_V1X = 3'd2;
    localparam t_cfg_idx REG_V1Y = 3'd3;
    localparam t_cfg_idx REG_V2X = 3'd4;
    localparam t_cfg_idx REG_V2Y = 3'd5;

    // distance result, unsigned with the coordinate scale
    localparam int DIST_BITS = 26;
    typedef logic [DIST_BITS-1:0] t_dist;
    localparam t_dist DIST_MAX = '1;

    // region codes
    localparam int REGION_W = 3;
    typedef logic [REGION_W-1:0] t_region;
    localparam t_region REGION_INSIDE   = 3'd0;
    localparam t_region REGION_EDGE_12  = 3'd1;
    localparam t_region REGION_CORNER_2 = 3'd2;
    localparam t_region REGION_EDGE_20  = 3'd3;
    localparam t_region REGION_CORNER_0 = 3'd4;
    localparam t_region REGION_EDGE_01  = 3'd5;
    localparam t_region REGION_CORNER_1 = 3'd6;

endpackage

// ===== src/point_triangle_distance_2d_core.sv =====
// ----------------------------------------------------------------------------
// point_triangle_distance_2d_core
// Euclidean distance from a query point to a configured triangle, with
// region code and degenerate flag
// ----------------------------------------------------------------------------
// Takes one query point per clock while the skid entry is empty and returns
// one result per item, in order. The pipeline holds the restoring divider
// (one quotient bit per stage, three sides in parallel) and the square root
// (one root bit per stage) that follow six stages of products, sums and
// region sorting. An output register with one skid entry lets the pipeline
// take items while a result waits. The distance is the exact distance
// rounded to nearest with halves rounded up, on the same fixed-point scale
// as the coordinates, saturating at the top code. A zero-area triangle gives
// degenerate 1, region 0 and the top distance code. Vertex registers are
// written through the configuration channel (indexes 0 to 5, others ignored)
// by the user only while no item is in flight; the block does not enforce it.
`include "point_triangle_distance_2d_core_assert.svh"

module point_triangle_distance_2d_core #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ptd2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]     i_point_x,
    input  logic signed [COORD_WIDTH-1:0]     i_point_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ptd2d_pkg::DIST_BITS-1:0]   o_distance,
    output ptd2d_pkg::t_region                o_region,
    output logic                              o_degenerate
);
    import ptd2d_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;            // coordinate difference
    localparam int PW   = 2 * DW;            // one product
    localparam int SMW  = 2 * DW + 1;        // sum of two products
    localparam int LW   = 2 * DW - 1;        // squared length, divisor
    localparam int CRW  = 2 * DW - 1;        // cross product magnitude
    localparam int HLW  = (CRW + 1) / 2;
    localparam int HHW  = CRW - HLW;
    localparam int QW   = 2 * DW + 1;        // quotient, four times squared distance
    localparam int NW   = 2 * CRW + 2;       // dividend
    localparam int SW   = (QW + 1) / 2;      // square root
    localparam int RMW  = SW + 2;            // root remainder
    localparam int XW   = (SW > DIST_BITS) ? SW : DIST_BITS;
    localparam int NST  = 7 + QW + SW;       // pipeline stages before output register

    // vertex registers
    logic signed [CW-1:0] r_v0x, r_v0y, r_v1x, r_v1y, r_v2x, r_v2y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0x <= '0;
            r_v0y <= '0;
            r_v1x <= '0;
            r_v1y <= '0;
            r_v2x <= '0;
            r_v2y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_V0X: r_v0x <= i_cfg_data;
                REG_V0Y: r_v0y <= i_cfg_data;
                REG_V1X: r_v1x <= i_cfg_data;
                REG_V1Y: r_v1y <= i_cfg_data;
                REG_V2X: r_v2x <= i_cfg_data;
                REG_V2Y: r_v2y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic           r_skid_vld;
    logic           r_out_vld;
    logic           pipe_en;
    logic [NST-1:0] r_vld;

    assign pipe_en    = !r_skid_vld;
    assign o_in_ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    logic signed [CW-1:0] vx [3];
    logic signed [CW-1:0] vy [3];
    assign vx[0] = r_v0x;
    assign vy[0] = r_v0y;
    assign vx[1] = r_v1x;
    assign vy[1] = r_v1y;
    assign vx[2] = r_v2x;
    assign vy[2] = r_v2y;

    // stage 1: triangle edges and offset of the point
    logic signed [DW-1:0] r1_e1x, r1_e1y, r1_dvx, r1_dvy;
    logic signed [DW-1:0] r1_relx [3];
    logic signed [DW-1:0] r1_rely [3];
    logic signed [DW-1:0] r1_dirx [3];
    logic signed [DW-1:0] r1_diry [3];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_e1x <= DW'(r_v2x) - DW'(r_v0x);
            r1_e1y <= DW'(r_v2y) - DW'(r_v0y);
            r1_dvx <= DW'(r_v0x) - DW'(i_point_x);
            r1_dvy <= DW'(r_v0y) - DW'(i_point_y);
        end
    end

    // stage 2: single products for area and barycentric crosses
    logic signed [PW-1:0] r2_ap0, r2_ap1, r2_sp0, r2_sp1, r2_tp0, r2_tp1;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_ap0 <= r1_dirx[0] * r1_e1y;
            r2_ap1 <= r1_diry[0] * r1_e1x;
            r2_sp0 <= r1_e1x * r1_dvy;
            r2_sp1 <= r1_e1y * r1_dvx;
            r2_tp0 <= r1_dvx * r1_diry[0];
            r2_tp1 <= r1_dvy * r1_dirx[0];
        end
    end

    // stage 3: area and barycentric crosses
    logic signed [SMW-1:0] r3_area, r3_su, r3_tv;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_area <= SMW'(r2_ap0) - SMW'(r2_ap1);
            r3_su   <= SMW'(r2_sp0) - SMW'(r2_sp1);
            r3_tv   <= SMW'(r2_tp0) - SMW'(r2_tp1);
        end
    end

    // stage 4: region sort
    logic                  area_neg, su_neg, tv_neg, inner, deg;
    logic signed [SMW+1:0] bary_diff;
    t_region               region_c;
    t_region               r4_region;
    logic                  r4_deg;

    always_comb begin
        deg       = (r3_area == '0);
        area_neg  = r3_area[SMW-1];
        su_neg    = (r3_su != '0) && (r3_su[SMW-1] != area_neg);
        tv_neg    = (r3_tv != '0) && (r3_tv[SMW-1] != area_neg);
        bary_diff = (SMW+2)'(r3_su) + (SMW+2)'(r3_tv) - (SMW+2)'(r3_area);
        inner     = area_neg ? !bary_diff[SMW+1]
                             : (bary_diff[SMW+1] || (bary_diff == '0));
        if (deg) begin
            region_c = REGION_INSIDE;
        end else if (inner) begin
            region_c = su_neg ? (tv_neg ? REGION_CORNER_0 : REGION_EDGE_20)
                              : (tv_neg ? REGION_EDGE_01 : REGION_INSIDE);
        end else begin
            region_c = su_neg ? REGION_CORNER_2 : (tv_neg ? REGION_CORNER_1 : REGION_EDGE_12);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_region <= region_c;
            r4_deg    <= deg;
        end
    end

    // stage 5 and 6 side data
    t_region r5_region;
    logic    r5_deg;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_region <= r4_region;
            r5_deg    <= r4_deg;
        end
    end

    // divider pipeline storage, index 0 is loaded by stage 6
    logic [LW-1:0] r_drem [QW+1][3];
    logic [QW-1:0] r_dq   [QW+1][3];
    logic [LW-1:0] r_dden [QW+1][3];
    t_region       r_dreg [QW+1];
    logic          r_ddeg [QW+1];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dreg[0] <= r5_region;
            r_ddeg[0] <= r5_deg;
        end
    end

    // per edge: squared distance as a quotient
    logic [LW-1:0] relsq_c [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_edge
        localparam int NX = (gi == 2) ? 0 : gi + 1;

        logic signed [PW-1:0]  r2_pj0, r2_pj1, r2_ln0, r2_ln1;
        logic signed [PW-1:0]  r2_rq0, r2_rq1, r2_cr0, r2_cr1;
        logic signed [SMW-1:0] r3_proj, r3_cr;
        logic [LW-1:0]         r3_len, r3_relsq;
        logic                  end_a, end_b;
        logic [CRW-1:0]        r4_crm;
        logic [LW-1:0]         r4_len, r4_epsq;
        logic                  r4_int;
        logic [2*HLW-1:0]      r5_ll;
        logic [HLW+HHW-1:0]    r5_lh;
        logic [2*HHW-1:0]      r5_hh;
        logic [LW-1:0]         r5_len, r5_epsq;
        logic                  r5_int;
        logic [2*CRW-1:0]      cr_sq;
        logic [NW-1:0]         dvd;

        // stage 1: edge direction and point relative to its start
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r1_relx[gi] <= DW'(i_point_x) - DW'(vx[gi]);
                r1_rely[gi] <= DW'(i_point_y) - DW'(vy[gi]);
                r1_dirx[gi] <= DW'(vx[NX]) - DW'(vx[gi]);
                r1_diry[gi] <= DW'(vy[NX]) - DW'(vy[gi]);
            end
        end

        // stage 2: products
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r2_pj0 <= r1_relx[gi] * r1_dirx[gi];
                r2_pj1 <= r1_rely[gi] * r1_diry[gi];
                r2_ln0 <= r1_dirx[gi] * r1_dirx[gi];
                r2_ln1 <= r1_diry[gi] * r1_diry[gi];
                r2_rq0 <= r1_relx[gi] * r1_relx[gi];
                r2_rq1 <= r1_rely[gi] * r1_rely[gi];
                r2_cr0 <= r1_dirx[gi] * r1_rely[gi];
                r2_cr1 <= r1_diry[gi] * r1_relx[gi];
            end
        end

        // stage 3: projection, lengths and cross product
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r3_proj  <= SMW'(r2_pj0) + SMW'(r2_pj1);
                r3_len   <= LW'(SMW'(r2_ln0) + SMW'(r2_ln1));
                r3_relsq <= LW'(SMW'(r2_rq0) + SMW'(r2_rq1));
                r3_cr    <= SMW'(r2_cr0) - SMW'(r2_cr1);
            end
        end

        assign relsq_c[gi] = r3_relsq;

        // stage 4: nearest point on the segment is an end or the interior
        always_comb begin
            end_a = r3_proj[SMW-1] || (r3_proj == '0);
            end_b = !end_a && ($unsigned(r3_proj) >= SMW'(r3_len));
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r4_int  <= !end_a && !end_b;
                r4_epsq <= end_a ? relsq_c[gi] : relsq_c[NX];
                r4_len  <= r3_len;
                r4_crm  <= CRW'(r3_cr[SMW-1] ? -r3_cr : r3_cr);
            end
        end

        // stage 5: partial products of the squared cross product
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r5_ll   <= r4_crm[HLW-1:0] * r4_crm[HLW-1:0];
                r5_lh   <= r4_crm[HLW-1:0] * r4_crm[CRW-1:HLW];
                r5_hh   <= r4_crm[CRW-1:HLW] * r4_crm[CRW-1:HLW];
                r5_int  <= r4_int;
                r5_len  <= r4_len;
                r5_epsq <= r4_epsq;
            end
        end

        // stage 6: dividend is four times the squared distance numerator
        always_comb begin
            cr_sq = ((2*CRW)'(r5_hh) << (2*HLW)) + ((2*CRW)'(r5_lh) << (HLW+1))
                  + (2*CRW)'(r5_ll);
            dvd   = r5_int ? {cr_sq, 2'b00} : NW'({r5_epsq, 2'b00});
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_drem[0][gi] <= dvd[NW-1:QW];
                r_dq[0][gi]   <= dvd[QW-1:0];
                r_dden[0][gi] <= r5_int ? r5_len : LW'(1);
            end
        end

        // restoring divider, one quotient bit per stage
        for (genvar k = 0; k < QW; k++) begin : g_div
            logic [LW:0]   trial;
            logic          ge;
            logic [LW-1:0] nrem;

            always_comb begin
                trial = {r_drem[k][gi], r_dq[k][gi][QW-1]};
                ge    = trial >= {1'b0, r_dden[k][gi]};
                nrem  = ge ? LW'(trial - {1'b0, r_dden[k][gi]}) : trial[LW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (pipe_en) begin
                    r_drem[k+1][gi] <= nrem;
                    r_dq[k+1][gi]   <= {r_dq[k][gi][QW-2:0], ge};
                    r_dden[k+1][gi] <= r_dden[k][gi];
                end
            end
        end
    end

    // side data through the divider
    for (genvar k = 0; k < QW; k++) begin : g_div_side
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_dreg[k+1] <= r_dreg[k];
                r_ddeg[k+1] <= r_ddeg[k];
            end
        end
    end

    // square root pipeline storage, index 0 is loaded by the minimum stage
    logic [RMW-1:0]  r_srem  [SW+1];
    logic [SW-1:0]   r_sroot [SW+1];
    logic [2*SW-1:0] r_srest [SW+1];
    t_region         r_sreg  [SW+1];
    logic            r_sdeg  [SW+1];

    // smallest of the quotients of the three triangle sides
    logic [QW-1:0] q0, q1, q2, qmin;
    logic          c01, c02, c12;

    always_comb begin
        q0   = r_dq[QW][0];
        q1   = r_dq[QW][1];
        q2   = r_dq[QW][2];
        c01  = q0 <= q1;
        c02  = q0 <= q2;
        c12  = q1 <= q2;
        if (c01 && c02) begin
            qmin = q0;
        end else if (!c01 && c12) begin
            qmin = q1;
        end else begin
            qmin = q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_srest[0] <= (2*SW)'(qmin);
            r_sreg[0]  <= r_dreg[QW];
            r_sdeg[0]  <= r_ddeg[QW];
        end
    end

    // integer square root, one root bit per stage
    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        logic [RMW+1:0] rem2, trial;
        logic           ge;

        always_comb begin
            rem2  = {r_srem[j], r_srest[j][2*SW-1:2*SW-2]};
            trial = (RMW+2)'({r_sroot[j], 2'b01});
            ge    = rem2 >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_srem[j+1]  <= RMW'(ge ? rem2 - trial : rem2);
                r_sroot[j+1] <= {r_sroot[j][SW-2:0], ge};
                r_srest[j+1] <= {r_srest[j][2*SW-3:0], 2'b00};
                r_sreg[j+1]  <= r_sreg[j];
                r_sdeg[j+1]  <= r_sdeg[j];
            end
        end
    end

    // round half up: largest odd root bound, then saturate; degenerate items give the top code, inside items zero
    logic [SW:0]   root_inc;
    logic [XW-1:0] dist_ext;
    t_dist         dist_c;

    always_comb begin
        root_inc = (SW+1)'(r_sroot[SW]) + (SW+1)'(1);
        dist_ext = XW'(root_inc[SW:1]);
        if (r_sdeg[SW]) begin
            dist_c = DIST_MAX;
        end else if (r_sreg[SW] == REGION_INSIDE) begin
            dist_c = '0;
        end else if (dist_ext > XW'(DIST_MAX)) begin
            dist_c = DIST_MAX;
        end else begin
            dist_c = DIST_BITS'(dist_ext);
        end
    end

    // output register with one skid entry
    logic    fin_vld;
    t_dist   r_out_dist, r_skid_dist;
    t_region r_out_reg, r_skid_reg;
    logic    r_out_deg, r_skid_deg;

    assign fin_vld = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_out_ready) begin
            r_out_vld <= fin_vld;
        end else if (fin_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out_dist <= r_skid_dist;
                r_out_reg  <= r_skid_reg;
                r_out_deg  <= r_skid_deg;
            end
        end else if (!r_out_vld || i_out_ready) begin
            r_out_dist <= dist_c;
            r_out_reg  <= r_sreg[SW];
            r_out_deg  <= r_sdeg[SW];
        end else begin
            r_skid_dist <= dist_c;
            r_skid_reg  <= r_sreg[SW];
            r_skid_deg  <= r_sdeg[SW];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_distance   = r_out_dist;
    assign o_region     = r_out_reg;
    assign o_degenerate = r_out_deg;

    // checks
    `PTD2D_ASSERT_NOW(a_skid_has_out, r_skid_vld, r_out_vld, "skid item without output item")
    `PTD2D_ASSERT_NOW(a_skid_fill, $rose(r_skid_vld), $past(r_out_vld && !i_out_ready), "skid filled while output free")
    `PTD2D_ASSERT_NEXT(a_skid_drain, r_skid_vld && i_out_ready, !r_skid_vld, "skid item not moved on")
    `PTD2D_ASSERT_NOW(a_deg_result, o_out_valid && o_degenerate, (o_distance == DIST_MAX) && (o_region == REGION_INSIDE), "degenerate item with wrong result")
    `PTD2D_ASSERT_NOW(a_inside_zero, o_out_valid && !o_degenerate && (o_region == REGION_INSIDE), o_distance == '0, "inside item with nonzero distance")

endmodule
